// ===== hdl/utf8_stream_decoder_core_macros.svh =====
// assertion helpers for the utf8 stream decoder
`ifndef UTF8_STREAM_DECODER_CORE_MACROS_SVH
`define UTF8_STREAM_DECODER_CORE_MACROS_SVH

// condition must never hold outside reset
`define UTF8SD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define UTF8SD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define UTF8SD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/utf8sd_pkg.sv =====
`timescale 1ns / 1ps

package utf8sd_pkg;

	localparam int CP_W    = 21;
	localparam int NB_W    = 3;
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic [CP_W-1:0] cp;
		logic            err;
		logic [NB_W-1:0] nb;
	} result_t;

	// one or two results caused by one text word
	typedef struct packed {
		result_t first;
		result_t second;
		logic    two;
	} packet_t;

	typedef struct packed {
		logic    push;
		packet_t pkt;
	} push_t;

	typedef struct packed {
		logic    empty;
		logic    full;
		packet_t head;
	} q_status_t;

endpackage

// ===== hdl/utf8sd_front.sv =====
`timescale 1ns / 1ps

module utf8sd_front import utf8sd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] text_byte,
	input  logic       q_full,
	output push_t      q_push
);

	logic [CP_W-1:0] acc_q, acc_n;
	logic [1:0]      rem_q, rem_n;
	logic [NB_W-1:0] len_q, len_n;

	logic            st_has, st_lead;
	result_t         st_res;
	logic [CP_W-1:0] st_acc;
	logic [1:0]      st_rem;
	logic [NB_W-1:0] st_len;

	logic            push_c;
	packet_t         pkt_c;
	logic [CP_W-1:0] shifted;
	logic            accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	// decode of a word with no sequence open
	always_comb begin
		st_has  = 1'b0;
		st_lead = 1'b0;
		st_res  = '0;
		st_acc  = '0;
		st_rem  = '0;
		st_len  = '0;
		priority if (!text_byte[7]) begin
			st_has    = 1'b1;
			st_res.cp = {{(CP_W-8){1'b0}}, text_byte};
			st_res.nb = NB_W'(1);
		end else if (text_byte[7:6] == 2'b10) begin
			st_has     = 1'b1;
			st_res.err = 1'b1;
			st_res.nb  = NB_W'(1);
		end else if (text_byte[7:5] == 3'b110) begin
			st_lead = 1'b1;
			st_acc  = {{(CP_W-5){1'b0}}, text_byte[4:0]};
			st_rem  = 2'd1;
			st_len  = NB_W'(2);
		end else if (text_byte[7:4] == 4'b1110) begin
			st_lead = 1'b1;
			st_acc  = {{(CP_W-4){1'b0}}, text_byte[3:0]};
			st_rem  = 2'd2;
			st_len  = NB_W'(3);
		end else if (text_byte[7:3] == 5'b11110) begin
			st_lead = 1'b1;
			st_acc  = {{(CP_W-3){1'b0}}, text_byte[2:0]};
			st_rem  = 2'd3;
			st_len  = NB_W'(4);
		end else begin
			st_has     = 1'b1;
			st_res.err = 1'b1;
			st_res.nb  = NB_W'(1);
		end
	end

	assign shifted = {acc_q[CP_W-7:0], text_byte[5:0]};

	always_comb begin
		push_c = 1'b0;
		pkt_c  = '0;
		acc_n  = acc_q;
		rem_n  = rem_q;
		len_n  = len_q;
		if (rem_q != 2'd0) begin
			if (text_byte[7:6] == 2'b10) begin
				acc_n = shifted;
				rem_n = rem_q - 2'd1;
				if (rem_q == 2'd1) begin
					push_c         = 1'b1;
					pkt_c.first.cp = shifted;
					pkt_c.first.nb = len_q;
					acc_n          = '0;
					len_n          = '0;
				end
			end else begin
				// broken sequence, then the word is decoded afresh as a result or a new lead
				push_c          = 1'b1;
				pkt_c.first.err = 1'b1;
				pkt_c.first.nb  = len_q - {1'b0, rem_q};
				acc_n           = '0;
				rem_n           = '0;
				len_n           = '0;
				if (st_has) begin
					pkt_c.two    = 1'b1;
					pkt_c.second = st_res;
				end else if (st_lead) begin
					acc_n = st_acc;
					rem_n = st_rem;
					len_n = st_len;
				end
			end
		end else begin
			if (st_has) begin
				push_c      = 1'b1;
				pkt_c.first = st_res;
			end else if (st_lead) begin
				acc_n = st_acc;
				rem_n = st_rem;
				len_n = st_len;
			end
		end
	end

	assign q_push.push = accept && push_c;
	assign q_push.pkt  = pkt_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			rem_q <= '0;
			len_q <= '0;
		end else if (accept) begin
			acc_q <= acc_n;
			rem_q <= rem_n;
			len_q <= len_n;
		end
	end

endmodule

// ===== hdl/utf8sd_queue.sv =====
`timescale 1ns / 1ps

module utf8sd_queue import utf8sd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  push_t     q_push,
	input  logic      pop,
	output q_status_t q_stat
);

	`include "utf8_stream_decoder_core_macros.svh"

	packet_t         mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wptr_q, rptr_q;
	logic [Q_CW-1:0] count_q;

	assign q_stat.empty = (count_q == Q_CW'(0));
	assign q_stat.full  = (count_q == Q_CW'(Q_DEPTH));
	assign q_stat.head  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (q_push.push) begin
			mem_q[wptr_q] <= q_push.pkt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (q_push.push) begin
				wptr_q <= wptr_q + Q_AW'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + Q_AW'(1);
			end
			if (q_push.push && !pop) begin
				count_q <= count_q + Q_CW'(1);
			end else if (!q_push.push && pop) begin
				count_q <= count_q - Q_CW'(1);
			end
		end
	end

	`UTF8SD_ASSERT_NEVER(a_push_full, clk, arst_n, q_push.push && q_stat.full, "push into full queue")
	`UTF8SD_ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && q_stat.empty, "pop from empty queue")
	`UTF8SD_ASSERT_NEVER(a_count_range, clk, arst_n, count_q > Q_CW'(Q_DEPTH), "queue count overflow")
	`UTF8SD_ASSERT_NEXT(a_count_up, clk, arst_n, q_push.push && !pop, count_q == $past(count_q) + Q_CW'(1), "queue count did not rise")

endmodule

// ===== hdl/utf8sd_back.sv =====
`timescale 1ns / 1ps

module utf8sd_back import utf8sd_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  q_status_t       q_stat,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [CP_W-1:0] code_point,
	output logic            is_error,
	output logic [NB_W-1:0] seq_bytes,
	output logic            last_of_run
);

	packet_t pkt_q;
	logic    vld_q;
	logic    phase_q;
	logic    take;
	logic    done;
	result_t cur;

	assign take = vld_q && !out_stall;
	assign done = take && (!pkt_q.two || phase_q);
	assign pop  = !q_stat.empty && (!vld_q || done);

	assign cur         = phase_q ? pkt_q.second : pkt_q.first;
	assign out_valid   = vld_q;
	assign code_point  = cur.cp;
	assign is_error    = cur.err;
	assign seq_bytes   = cur.nb;
	assign last_of_run = !pkt_q.two || phase_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			pkt_q <= q_stat.head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (pop) begin
				vld_q   <= 1'b1;
				phase_q <= 1'b0;
			end else if (done) begin
				vld_q   <= 1'b0;
				phase_q <= 1'b0;
			end else if (take) begin
				phase_q <= 1'b1;
			end
		end
	end

endmodule

// ===== hdl/utf8_stream_decoder_core.sv =====
// path: an accepted text word is written into the queue, then popped into the output register
// throughput: one text word per cycle while the queue is not full; a broken sequence followed
// by a word that gives its own result puts two results on the single result port
// a four-entry queue between decode and output absorbs the extra results and output stalls
// reset: arst_n asynchronous active low, clears the open sequence, queue and output valid
`timescale 1ns / 1ps

module utf8_stream_decoder_core import utf8sd_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [7:0]      text_byte,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [CP_W-1:0] code_point,
	output logic            is_error,
	output logic [NB_W-1:0] seq_bytes,
	output logic            last_of_run
);

	push_t     q_push;
	q_status_t q_stat;
	logic      pop;

	utf8sd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.text_byte (text_byte),
		.q_full    (q_stat.full),
		.q_push    (q_push)
	);

	utf8sd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_push (q_push),
		.pop    (pop),
		.q_stat (q_stat)
	);

	utf8sd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.code_point  (code_point),
		.is_error    (is_error),
		.seq_bytes   (seq_bytes),
		.last_of_run (last_of_run)
	);

endmodule

// ===== dv/utf8_decode_checker.sv =====
`timescale 1ns / 1ps

module utf8_decode_checker import utf8sd_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_stall,
	input  logic [7:0]      text_byte,
	input  logic            out_valid,
	input  logic            out_stall,
	input  logic [CP_W-1:0] code_point,
	input  logic            is_error,
	input  logic [NB_W-1:0] seq_bytes,
	input  logic            last_of_run,
	output int              fail_count,
	output int              words_pending
);

	typedef struct packed {
		result_t res;
		logic    last;
	} decoded_word_t;

	decoded_word_t   decoded_q [$];
	logic [CP_W-1:0] partial_cp;
	logic [1:0]      cont_left;
	logic [NB_W-1:0] char_len;

	// no sequence open: ascii, stray, invalid lead, or a lead that opens one
	task automatic open_or_emit(input logic [7:0] b, output result_t r, inout int n);
		r = '{cp: '0, err: 1'b1, nb: NB_W'(1)};
		casez (b)
			8'b0???????: begin
				r = '{cp: CP_W'(b), err: 1'b0, nb: NB_W'(1)};
				n++;
			end
			8'b10??????: n++;
			8'b110?????: begin
				partial_cp = CP_W'(b[4:0]);
				cont_left  = 2'd1;
				char_len   = NB_W'(2);
			end
			8'b1110????: begin
				partial_cp = CP_W'(b[3:0]);
				cont_left  = 2'd2;
				char_len   = NB_W'(3);
			end
			8'b11110???: begin
				partial_cp = CP_W'(b[2:0]);
				cont_left  = 2'd3;
				char_len   = NB_W'(4);
			end
			default: n++;
		endcase
	endtask

	task automatic decode_text_word(input logic [7:0] b);
		result_t       r [2];
		int            n;
		decoded_word_t w;
		n = 0;
		if (cont_left != 2'd0) begin
			if (b[7:6] == 2'b10) begin
				partial_cp = {partial_cp[CP_W-7:0], b[5:0]};
				cont_left  = cont_left - 2'd1;
				if (cont_left == 2'd0) begin
					r[0] = '{cp: partial_cp, err: 1'b0, nb: char_len};
					n = 1;
					partial_cp = '0;
					char_len   = '0;
				end
			end else begin
				// broken sequence, then the word is decoded afresh
				r[0] = '{cp: '0, err: 1'b1, nb: char_len - NB_W'(cont_left)};
				n = 1;
				partial_cp = '0;
				cont_left  = '0;
				char_len   = '0;
				open_or_emit(b, r[1], n);
			end
		end else begin
			open_or_emit(b, r[0], n);
		end
		for (int i = 0; i < n; i++) begin
			w.res  = r[i];
			w.last = (i == n - 1);
			decoded_q.push_back(w);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		decoded_word_t w;
		if (!arst_n) begin
			decoded_q.delete();
			partial_cp     = '0;
			cont_left      = '0;
			char_len       = '0;
			fail_count    <= 0;
			words_pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (decoded_q.size() == 0) begin
					$error("unexpected result: code_point %0h is_error %0b seq_bytes %0d",
						code_point, is_error, seq_bytes);
					fail_count <= fail_count + 1;
				end else begin
					w = decoded_q.pop_front();
					if (code_point !== w.res.cp || is_error !== w.res.err ||
						seq_bytes !== w.res.nb || last_of_run !== w.last) begin
						if (code_point !== w.res.cp)
							$error("code_point: expected %0h actual %0h", w.res.cp, code_point);
						if (is_error !== w.res.err)
							$error("is_error: expected %0b actual %0b", w.res.err, is_error);
						if (seq_bytes !== w.res.nb)
							$error("seq_bytes: expected %0d actual %0d", w.res.nb, seq_bytes);
						if (last_of_run !== w.last)
							$error("last_of_run: expected %0b actual %0b", w.last, last_of_run);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && !in_stall)
				decode_text_word(text_byte);
			words_pending <= decoded_q.size();
		end
	end

endmodule

// ===== dv/tb_utf8_stream_decoder_core.sv =====
`timescale 1ns / 1ps

module tb_utf8_stream_decoder_core;
	import utf8sd_pkg::*;

	localparam int PHASE_WORDS = 120;
	localparam int DRAIN_LIMIT = 20000;
	localparam logic [7:0] DIRECTED_TEXT [25] = '{
		8'h00, 8'h7F, 8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF7, 8'hBF, 8'hBF,
		8'hBF, 8'h80, 8'hBF, 8'hF8, 8'hFF, 8'hC3, 8'h41, 8'hE2, 8'h82, 8'hC3,
		8'hA9, 8'hF0, 8'h90, 8'h80, 8'hF8
	};

	logic            clk       = 1'b0;
	logic            arst_n    = 1'b0;
	logic            in_valid  = 1'b0;
	logic            in_stall;
	logic [7:0]      text_byte = 8'h00;
	logic            out_valid;
	logic            out_stall = 1'b0;
	logic [CP_W-1:0] code_point;
	logic            is_error;
	logic [NB_W-1:0] seq_bytes;
	logic            last_of_run;
	int              fail_count;
	int              words_pending;
	int              send_idle_pct = 0;
	int              stall_pct     = 0;
	int              words_sent    = 0;

	always #6 clk = ~clk;

	always @(posedge clk)
		out_stall <= ($urandom_range(99, 0) < stall_pct);

	utf8_stream_decoder_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.text_byte   (text_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.code_point  (code_point),
		.is_error    (is_error),
		.seq_bytes   (seq_bytes),
		.last_of_run (last_of_run)
	);

	utf8_decode_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.text_byte     (text_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.code_point    (code_point),
		.is_error      (is_error),
		.seq_bytes     (seq_bytes),
		.last_of_run   (last_of_run),
		.fail_count    (fail_count),
		.words_pending (words_pending)
	);

	task automatic send_text_word(input logic [7:0] b);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		text_byte <= b;
		do @(posedge clk); while (in_stall);
		words_sent++;
	endtask

	function automatic logic [7:0] cont_word();
		return {2'b10, 6'($urandom)};
	endfunction

	// mostly well-formed characters, some broken sequences and raw noise
	task automatic send_random_text(input int target);
		int kind;
		int len;
		int conts;
		logic [7:0] b;
		while (words_sent < target) begin
			kind = $urandom_range(99, 0);
			if (kind < 30) begin
				send_text_word({1'b0, 7'($urandom)});
			end else if (kind < 75) begin
				len = (kind < 45) ? 2 : (kind < 60) ? 3 : 4;
				case (len)
					2: send_text_word({3'b110, 5'($urandom)});
					3: send_text_word({4'b1110, 4'($urandom)});
					default: send_text_word({5'b11110, 3'($urandom)});
				endcase
				for (int i = 1; i < len; i++)
					send_text_word(cont_word());
			end else if (kind < 88) begin
				len   = $urandom_range(4, 2);
				conts = $urandom_range(len - 2, 0);
				case (len)
					2: send_text_word({3'b110, 5'($urandom)});
					3: send_text_word({4'b1110, 4'($urandom)});
					default: send_text_word({5'b11110, 3'($urandom)});
				endcase
				for (int i = 0; i < conts; i++)
					send_text_word(cont_word());
				b = 8'($urandom);
				if (b[7:6] == 2'b10)
					b[6] = 1'b1;
				send_text_word(b);
			end else begin
				send_text_word(8'($urandom));
			end
		end
	endtask

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		int drain_cycles;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DIRECTED_TEXT[i])
			send_text_word(DIRECTED_TEXT[i]);
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 88; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 88; end
				default: begin send_idle_pct = 29; stall_pct = 29; end
			endcase
			send_random_text(words_sent + PHASE_WORDS);
			// hold off until every decoded word has drained
			in_valid <= 1'b0;
			do @(posedge clk); while (words_pending != 0);
		end
		in_valid <= 1'b0;
		drain_cycles = 0;
		do begin
			@(posedge clk);
			drain_cycles++;
		end while (words_pending != 0 && drain_cycles < DRAIN_LIMIT);
		repeat (8) @(posedge clk);
		if (fail_count == 0 && words_pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
